FILE: src/mpl_pkg.sv
// Shared types, constants and state codes of the mesh point location walk unit.
`timescale 1ns / 1ps
`default_nettype none
package mpl_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int CoordBits = 24;
   localparam int IdxBits   = 12;
   localparam int StampBits = 16;

   // Default store depths.
   localparam int DefMaxTriangles = 4096;
   localparam int DefMaxPoints    = 4096;

   // Operation codes.
   localparam logic [1:0] OP_LOAD_POINT = 2'd0;
   localparam logic [1:0] OP_LOAD_TRI   = 2'd1;
   localparam logic [1:0] OP_LOCATE     = 2'd2;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_INSIDE    = 2'd0;
   localparam logic [1:0] ST_VERTEX    = 2'd1;
   localparam logic [1:0] ST_REVISIT   = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]                  op;
      logic [IdxBits-1:0]          index;
      logic signed [CoordBits-1:0] coord_x;
      logic signed [CoordBits-1:0] coord_y;
      logic [IdxBits-1:0]          vertex_a;
      logic [IdxBits-1:0]          vertex_b;
      logic [IdxBits-1:0]          vertex_c;
      logic [IdxBits-1:0]          neighbour_a;
      logic [IdxBits-1:0]          neighbour_b;
      logic [IdxBits-1:0]          neighbour_c;
   } req_type;

   typedef struct packed {
      logic [IdxBits-1:0] found_triangle;
      logic [1:0]         status;
   } rsp_type;

   // One entry of the point store.
   typedef struct packed {
      logic signed [CoordBits-1:0] x;
      logic signed [CoordBits-1:0] y;
   } point_rec_type;

   // One entry of the triangle store.
   typedef struct packed {
      logic [IdxBits-1:0] va;
      logic [IdxBits-1:0] vb;
      logic [IdxBits-1:0] vc;
      logic [IdxBits-1:0] na;
      logic [IdxBits-1:0] nb;
      logic [IdxBits-1:0] nc;
   } tri_rec_type;

   // Signs of the triangle area and the three sub-areas.
   typedef struct packed {
      logic       dd_pos;
      logic [2:0] a_neg;
      logic [2:0] a_pos;
   } area_sign_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_QRD,
      S_QCAP,
      S_TRI,
      S_TCHK,
      S_P0,
      S_P1,
      S_P2,
      S_AREA
   } walk_state_type;

endpackage
`default_nettype wire

FILE: src/mpl_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mpl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: src/mpl_area_unit.sv
// Sequential area unit: triangle orientation and three oriented sub-areas.
`timescale 1ns / 1ps
`default_nettype none
module mpl_area_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [mpl_pkg::CoordBits-1:0] x0,
   input  wire logic signed [mpl_pkg::CoordBits-1:0] y0,
   input  wire logic signed [mpl_pkg::CoordBits-1:0] x1,
   input  wire logic signed [mpl_pkg::CoordBits-1:0] y1,
   input  wire logic signed [mpl_pkg::CoordBits-1:0] x2,
   input  wire logic signed [mpl_pkg::CoordBits-1:0] y2,
   input  wire logic signed [mpl_pkg::CoordBits-1:0] qx,
   input  wire logic signed [mpl_pkg::CoordBits-1:0] qy,
   output logic                                      done,
   output mpl_pkg::area_sign_type                    sign
);
   import mpl_pkg::*;

   localparam int DW = CoordBits + 1;
   localparam int PW = 2 * DW;
   localparam int AW = PW + 1;

   logic signed [DW-1:0] d10x_ff, d20y_ff, d10y_ff, d20x_ff;
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [DW-1:0] opa, opb, opc, opd;
   logic signed [PW-1:0] pa_ff, pb_ff;
   logic signed [AW-1:0] area;
   logic                 active_ff, phase_ff, done_ff;
   logic [1:0]           k_ff;
   area_sign_type        sign_ff;

   // Operand selection for the two products of the current area.
   always_comb begin
      case (k_ff)
         2'd0: begin
            opa = d10x_ff; opb = d20y_ff; opc = d10y_ff; opd = d20x_ff;
         end
         2'd1: begin
            opa = bx_ff; opb = cy_ff; opc = by_ff; opd = cx_ff;
         end
         2'd2: begin
            opa = cx_ff; opb = ay_ff; opc = cy_ff; opd = ax_ff;
         end
         default: begin
            opa = ax_ff; opb = by_ff; opc = ay_ff; opd = bx_ff;
         end
      endcase
   end

   assign area = AW'(pa_ff) - AW'(pb_ff);

   // Differences are taken once at start.
   always_ff @(posedge clock) begin
      if (start) begin
         d10x_ff <= {x1[CoordBits-1], x1} - {x0[CoordBits-1], x0};
         d20y_ff <= {y2[CoordBits-1], y2} - {y0[CoordBits-1], y0};
         d10y_ff <= {y1[CoordBits-1], y1} - {y0[CoordBits-1], y0};
         d20x_ff <= {x2[CoordBits-1], x2} - {x0[CoordBits-1], x0};
         ax_ff   <= {x0[CoordBits-1], x0} - {qx[CoordBits-1], qx};
         ay_ff   <= {y0[CoordBits-1], y0} - {qy[CoordBits-1], qy};
         bx_ff   <= {x1[CoordBits-1], x1} - {qx[CoordBits-1], qx};
         by_ff   <= {y1[CoordBits-1], y1} - {qy[CoordBits-1], qy};
         cx_ff   <= {x2[CoordBits-1], x2} - {qx[CoordBits-1], qx};
         cy_ff   <= {y2[CoordBits-1], y2} - {qy[CoordBits-1], qy};
      end
   end

   // Products are registered in one phase, their difference and signs in the next.
   always_ff @(posedge clock) begin
      if (active_ff && !phase_ff) begin
         pa_ff <= opa * opb;
         pb_ff <= opc * opd;
      end
      if (active_ff && phase_ff) begin
         if (k_ff == 2'd0) begin
            sign_ff.dd_pos <= (area > 0);
         end else begin
            sign_ff.a_neg[2'(k_ff - 2'd1)] <= (area < 0);
            sign_ff.a_pos[2'(k_ff - 2'd1)] <= (area > 0);
         end
      end
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 1'b0;
         k_ff      <= 2'd0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            phase_ff  <= 1'b0;
            k_ff      <= 2'd0;
         end else if (active_ff) begin
            phase_ff <= !phase_ff;
            if (phase_ff) begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  active_ff <= 1'b0;
                  done_ff   <= 1'b1;
               end
            end
         end
      end
   end

   assign done = done_ff;
   assign sign = sign_ff;

endmodule
`default_nettype wire

FILE: src/mesh_point_location_walk_unit.sv
// Top level: mesh stores, visit marks and the walk sequencer.
// A load is written as it is accepted and leaves busy low. A locate holds busy to read the
// query point, skip each deleted triangle, cross each live one (record, vertices, area unit)
// and end on leaving range, on a revisit or vertex hit, or inside; the strobe rises as busy
// falls. A stamp wrap first clears the whole visit store. The receiver cannot stall.
// Reset clears the visit store the same way with busy high and sets tri_count to 1.
`timescale 1ns / 1ps
`default_nettype none
module mesh_point_location_walk_unit #(
   parameter int MAX_TRIANGLES = mpl_pkg::DefMaxTriangles,
   parameter int MAX_POINTS    = mpl_pkg::DefMaxPoints
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire mpl_pkg::req_type             req_data,
   output logic                              rsp_valid,
   output mpl_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [mpl_pkg::IdxBits-1:0]  csr_data
);
   import mpl_pkg::*;

   localparam int TA = $clog2(MAX_TRIANGLES);
   localparam int PA = $clog2(MAX_POINTS);
   localparam logic [16:0] MaxTri = 17'(MAX_TRIANGLES);
   localparam logic [16:0] MaxPt  = 17'(MAX_POINTS);
   localparam logic [TA-1:0] ClrLast = TA'(MAX_TRIANGLES - 1);
   localparam logic [StampBits-1:0] StampMax = '1;

   walk_state_type state_ff, state_in;
   logic [IdxBits:0]         iel_ff, iel_in;
   logic [IdxBits-1:0]       ip_ff, ip_in;
   logic [StampBits-1:0]     stamp_ff, stamp_in;
   logic [TA-1:0]            clr_ff, clr_in;
   logic                     pend_ff, pend_in;
   logic [IdxBits-1:0]       tri_count_ff;
   logic signed [CoordBits-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [CoordBits-1:0] x0_ff, x0_in, y0_ff, y0_in;
   logic signed [CoordBits-1:0] x1_ff, x1_in, y1_ff, y1_in;
   tri_rec_type              tri_ff, tri_in;
   logic                     poob_ff, poob_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // Memory ports.
   logic                     pt_we, tri_we, vis_we;
   logic [PA-1:0]            pt_waddr, pt_raddr;
   logic [TA-1:0]            tri_waddr, vis_waddr, tri_raddr;
   point_rec_type            pt_wdata, pt_rdata, pt_val;
   tri_rec_type              tri_wdata, tri_rdata;
   logic [StampBits-1:0]     vis_wdata, vis_rdata;
   logic [IdxBits-1:0]       pt_ridx;

   // Walk decisions.
   logic                     accept, in_range, v0_zero, visit_hit, vert_hit;
   logic                     area_start, area_done;
   area_sign_type            area_sign;
   logic [2:0]               edge_mv;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);

   // Point store: x and y of each point.
   mpl_ram #(.WIDTH($bits(point_rec_type)), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock (clock),
      .we    (pt_we),
      .waddr (pt_waddr),
      .wdata (pt_wdata),
      .raddr (pt_raddr),
      .rdata (pt_rdata)
   );

   // Triangle store: vertices and neighbours.
   mpl_ram #(.WIDTH($bits(tri_rec_type)), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
      .clock (clock),
      .we    (tri_we),
      .waddr (tri_waddr),
      .wdata (tri_wdata),
      .raddr (tri_raddr),
      .rdata (tri_rdata)
   );

   // Visit stamp store, read at the same address as the triangle store.
   mpl_ram #(.WIDTH(StampBits), .DEPTH(MAX_TRIANGLES)) u_visit_ram (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .raddr (tri_raddr),
      .rdata (vis_rdata)
   );

   // Area unit starts as the third vertex arrives from the point store.
   assign area_start = (state_ff == S_P2);

   mpl_area_unit u_area (
      .clock (clock),
      .reset (reset),
      .start (area_start),
      .x0    (x0_ff),
      .y0    (y0_ff),
      .x1    (x1_ff),
      .y1    (y1_ff),
      .x2    (pt_val.x),
      .y2    (pt_val.y),
      .qx    (qx_ff),
      .qy    (qy_ff),
      .done  (area_done),
      .sign  (area_sign)
   );

   // Load writes.
   assign pt_we     = accept && (req_data.op == OP_LOAD_POINT)
                      && (17'(req_data.index) < MaxPt);
   assign pt_waddr  = PA'(req_data.index);
   assign pt_wdata  = '{x: req_data.coord_x, y: req_data.coord_y};
   assign tri_we    = accept && (req_data.op == OP_LOAD_TRI)
                      && (17'(req_data.index) < MaxTri);
   assign tri_waddr = TA'(req_data.index);
   assign tri_wdata = '{va: req_data.vertex_a, vb: req_data.vertex_b,
                        vc: req_data.vertex_c, na: req_data.neighbour_a,
                        nb: req_data.neighbour_b, nc: req_data.neighbour_c};

   // Visit marks: cleared by the sweep, stamped when a triangle is entered.
   assign vis_we    = (state_ff == S_CLEAR) || ((state_ff == S_TCHK) && !v0_zero
                      && !visit_hit && !vert_hit);
   assign vis_waddr = (state_ff == S_CLEAR) ? clr_ff : TA'(iel_ff);
   assign vis_wdata = (state_ff == S_CLEAR) ? '0 : stamp_ff;

   // Read addresses.
   assign tri_raddr = TA'(iel_ff);

   always_comb begin
      case (state_ff)
         S_TCHK:  pt_ridx = tri_rdata.va;
         S_P0:    pt_ridx = tri_ff.vb;
         S_P1:    pt_ridx = tri_ff.vc;
         default: pt_ridx = ip_ff;
      endcase
   end

   assign pt_raddr = PA'(pt_ridx);
   assign poob_in  = !(17'(pt_ridx) < MaxPt);
   assign pt_val   = poob_ff ? '0 : pt_rdata;

   // Walk tests.
   assign in_range  = (iel_ff <= {1'b0, tri_count_ff}) && (17'(iel_ff) < MaxTri);
   assign v0_zero   = (tri_rdata.va == '0);
   assign visit_hit = (vis_rdata == stamp_ff);
   assign vert_hit  = (tri_rdata.va == ip_ff) || (tri_rdata.vb == ip_ff)
                      || (tri_rdata.vc == ip_ff);
   assign edge_mv[0] = (area_sign.dd_pos ? area_sign.a_neg[0] : area_sign.a_pos[0])
                       && (tri_ff.na != '0);
   assign edge_mv[1] = (area_sign.dd_pos ? area_sign.a_neg[1] : area_sign.a_pos[1])
                       && (tri_ff.nb != '0);
   assign edge_mv[2] = (area_sign.dd_pos ? area_sign.a_neg[2] : area_sign.a_pos[2])
                       && (tri_ff.nc != '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ClrLast) begin
               state_in = pend_ff ? S_QRD : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && (req_data.op == OP_LOCATE)) begin
               state_in = (stamp_ff == StampMax) ? S_CLEAR : S_QRD;
            end
         end
         S_QRD:  state_in = S_QCAP;
         S_QCAP: state_in = S_TRI;
         S_TRI:  state_in = in_range ? S_TCHK : S_IDLE;
         S_TCHK: begin
            if (v0_zero) begin
               state_in = S_TRI;
            end else if (visit_hit || vert_hit) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_P0;
            end
         end
         S_P0:   state_in = S_P1;
         S_P1:   state_in = S_P2;
         S_P2:   state_in = S_AREA;
         S_AREA: begin
            if (area_done) begin
               state_in = (edge_mv != 3'b000) ? S_TRI : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and result updates.
   always_comb begin
      iel_in       = iel_ff;
      ip_in        = ip_ff;
      stamp_in     = stamp_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      tri_in       = tri_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ClrLast) begin
               pend_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept && (req_data.op == OP_LOCATE)) begin
               ip_in = req_data.index;
               if (stamp_ff == StampMax) begin
                  stamp_in = StampBits'(1);
                  pend_in  = 1'b1;
                  clr_in   = '0;
               end else begin
                  stamp_in = stamp_ff + 1'b1;
               end
            end
         end
         S_QRD: begin
            iel_in = (IdxBits + 1)'(1);
         end
         S_QCAP: begin
            qx_in = pt_val.x;
            qy_in = pt_val.y;
         end
         S_TRI: begin
            if (!in_range) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{found_triangle: '0, status: ST_NOT_FOUND};
            end
         end
         S_TCHK: begin
            tri_in = tri_rdata;
            if (v0_zero) begin
               iel_in = iel_ff + 1'b1;
            end else if (visit_hit) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{found_triangle: iel_ff[IdxBits-1:0], status: ST_REVISIT};
            end else if (vert_hit) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{found_triangle: iel_ff[IdxBits-1:0], status: ST_VERTEX};
            end
         end
         S_P0: begin
            x0_in = pt_val.x;
            y0_in = pt_val.y;
         end
         S_P1: begin
            x1_in = pt_val.x;
            y1_in = pt_val.y;
         end
         S_AREA: begin
            if (area_done) begin
               if (edge_mv[0]) begin
                  iel_in = {1'b0, tri_ff.na};
               end else if (edge_mv[1]) begin
                  iel_in = {1'b0, tri_ff.nb};
               end else if (edge_mv[2]) begin
                  iel_in = {1'b0, tri_ff.nc};
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{found_triangle: iel_ff[IdxBits-1:0], status: ST_INSIDE};
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         stamp_ff     <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tri_count_ff <= IdxBits'(1);
      end else begin
         state_ff     <= state_in;
         stamp_ff     <= stamp_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tri_count_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      iel_ff  <= iel_in;
      ip_ff   <= ip_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      x0_ff   <= x0_in;
      y0_ff   <= y0_in;
      x1_ff   <= x1_in;
      y1_ff   <= y1_in;
      tri_ff  <= tri_in;
      poob_ff <= poob_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: dv/mesh_point_location_walk_unit_tb.sv
// Self-checking testbench of the mesh point location walk unit.
`timescale 1ns / 1ps
module mesh_point_location_walk_unit_tb;
   import mpl_pkg::*;

   localparam int CycleLimit = 3_000_000;
   localparam int PoolTop    = 31;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [IdxBits-1:0]  csr_data;

   // Shadow copy of the mesh as the block should hold it.
   logic signed [CoordBits-1:0] point_x [DefMaxPoints];
   logic signed [CoordBits-1:0] point_y [DefMaxPoints];
   bit                          point_loaded [DefMaxPoints];
   tri_rec_type                 mesh_tri [DefMaxTriangles];
   bit                          tri_loaded [DefMaxTriangles];
   logic [IdxBits-1:0]          walk_limit = 12'd1;

   rsp_type      awaited_answers [$];
   stim_row_type directed_rows [$];
   rsp_type      head;
   int           mismatches = 0;
   int           cycles = 0;
   int           accepted = 0;
   int           status_seen [4];
   bit           burst = 1'b0;

   mesh_point_location_walk_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Walks the shadow mesh from triangle 1. A fresh visit set per locate is
   // equivalent to the block's stamps. The unsafe flag marks a walk that
   // would read a store entry never written.
   function automatic void locate_answer(input logic [IdxBits-1:0] ip, output rsp_type ans,
                                         output bit unsafe);
      bit          seen [DefMaxTriangles];
      int          tri_at;
      tri_rec_type t;
      longint      qx, qy, x0, y0, x1, y1, x2, y2, dd, a1, a2, a3;
      bit          flip;
      unsafe = 1'b0;
      ans    = '0;
      tri_at = 1;
      if (!point_loaded[ip]) begin
         unsafe = 1'b1;
         return;
      end
      qx = longint'(point_x[ip]);
      qy = longint'(point_y[ip]);
      forever begin
         if (tri_at > walk_limit) begin
            ans.found_triangle = '0;
            ans.status = ST_NOT_FOUND;
            return;
         end
         if (!tri_loaded[tri_at]) begin
            unsafe = 1'b1;
            return;
         end
         t = mesh_tri[tri_at];
         if (t.va == '0) begin
            tri_at++;
            continue;
         end
         if (!point_loaded[t.va] || !point_loaded[t.vb] || !point_loaded[t.vc]) begin
            unsafe = 1'b1;
            return;
         end
         ans.found_triangle = tri_at[IdxBits-1:0];
         if (seen[tri_at]) begin
            ans.status = ST_REVISIT;
            return;
         end
         if (t.va == ip || t.vb == ip || t.vc == ip) begin
            ans.status = ST_VERTEX;
            return;
         end
         seen[tri_at] = 1'b1;
         x0 = longint'(point_x[t.va]); y0 = longint'(point_y[t.va]);
         x1 = longint'(point_x[t.vb]); y1 = longint'(point_y[t.vb]);
         x2 = longint'(point_x[t.vc]); y2 = longint'(point_y[t.vc]);
         dd = (x1 - x0) * (y2 - y0) - (y1 - y0) * (x2 - x0);
         flip = !(dd > 0);
         // Cross the first edge with a strictly negative sub-area.
         a1 = (x1 - qx) * (y2 - qy) - (y1 - qy) * (x2 - qx);
         if (flip) a1 = -a1;
         if (a1 < 0 && t.na != '0) begin
            tri_at = int'(t.na);
            continue;
         end
         a2 = (x2 - qx) * (y0 - qy) - (y2 - qy) * (x0 - qx);
         if (flip) a2 = -a2;
         if (a2 < 0 && t.nb != '0) begin
            tri_at = int'(t.nb);
            continue;
         end
         a3 = (x0 - qx) * (y1 - qy) - (y0 - qy) * (x1 - qx);
         if (flip) a3 = -a3;
         if (a3 < 0 && t.nc != '0) begin
            tri_at = int'(t.nc);
            continue;
         end
         ans.status = ST_INSIDE;
         return;
      end
   endfunction

   function automatic req_type point_load(input int idx, input int x, input int y);
      req_type r;
      r = '0;
      r.op = OP_LOAD_POINT;
      r.index = IdxBits'(idx);
      r.coord_x = CoordBits'(x);
      r.coord_y = CoordBits'(y);
      return r;
   endfunction

   function automatic req_type tri_load(input int idx, input int a, input int b, input int c,
                                        input int na, input int nb, input int nc);
      req_type r;
      r = '0;
      r.op = OP_LOAD_TRI;
      r.index = IdxBits'(idx);
      r.vertex_a = IdxBits'(a);
      r.vertex_b = IdxBits'(b);
      r.vertex_c = IdxBits'(c);
      r.neighbour_a = IdxBits'(na);
      r.neighbour_b = IdxBits'(nb);
      r.neighbour_c = IdxBits'(nc);
      return r;
   endfunction

   function automatic req_type locate_req(input int idx);
      req_type r;
      r = '0;
      r.op = OP_LOCATE;
      r.index = IdxBits'(idx);
      return r;
   endfunction

   // Offers one transaction after a random gap, then updates the shadow mesh
   // or queues the expected answer once the block has taken it.
   task automatic issue(input req_type r, input bit typed, input rsp_type want);
      int      gap;
      rsp_type ans;
      bit      unsafe;
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      accepted++;
      case (r.op)
         OP_LOAD_POINT: begin
            point_x[r.index] = r.coord_x;
            point_y[r.index] = r.coord_y;
            point_loaded[r.index] = 1'b1;
         end
         OP_LOAD_TRI: begin
            mesh_tri[r.index] = '{r.vertex_a, r.vertex_b, r.vertex_c,
                                  r.neighbour_a, r.neighbour_b, r.neighbour_c};
            tri_loaded[r.index] = 1'b1;
         end
         OP_LOCATE: begin
            locate_answer(r.index, ans, unsafe);
            if (typed) ans = want;
            awaited_answers.push_back(ans);
            status_seen[ans.status]++;
         end
         default: ;
      endcase
   endtask

   // Writes tri_count once the block has drained and gone idle.
   task automatic set_walk_limit(input logic [IdxBits-1:0] value);
      start <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      while (busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      walk_limit = value;
   endtask

   function automatic int pool_point();
      return ($urandom_range(0, 19) == 0) ? 4095 : $urandom_range(0, PoolTop);
   endfunction

   function automatic int pool_neighbour();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return 0;
      if (pick < 33) return 4095;
      return $urandom_range(1, PoolTop);
   endfunction

   // Mostly well-formed pool triangles with random links; a few stray loads.
   function automatic req_type pool_triangle(input int idx);
      return tri_load(idx, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, PoolTop),
                      $urandom_range(0, PoolTop), $urandom_range(0, PoolTop),
                      pool_neighbour(), pool_neighbour(), pool_neighbour());
   endfunction

   task automatic random_transaction();
      req_type r;
      rsp_type ans;
      bit      unsafe;
      int      pick;
      int      tries;
      r = ($bits(req_type))'({$urandom, $urandom, $urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         // Locate only points whose walk stays on written entries.
         tries = 0;
         do begin
            r.op = OP_LOCATE;
            r.index = IdxBits'(pool_point());
            locate_answer(r.index, ans, unsafe);
            tries++;
         end while (unsafe && tries < 8);
         if (unsafe) r.op = OP_LOAD_POINT;
      end else if (pick < 75) begin
         r.op = OP_LOAD_POINT;
         if ($urandom_range(0, 19) != 0) r.index = IdxBits'(pool_point());
         if ($urandom_range(0, 9) != 0) begin
            r.coord_x = CoordBits'($urandom_range(0, 400) - 200);
            r.coord_y = CoordBits'($urandom_range(0, 400) - 200);
         end
      end else if (pick < 96) begin
         r.op = OP_LOAD_TRI;
         if ($urandom_range(0, 9) != 0 || r.index <= PoolTop || r.index == 4095)
            r = pool_triangle($urandom_range(1, PoolTop));
      end else begin
         r.op = OP_UNUSED;
      end
      issue(r, 1'b0, '0);
   endtask

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("mesh_point_location_walk_unit verification failed");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (awaited_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: triangle %0d status %0d",
                        rsp_data.found_triangle, rsp_data.status);
         end else begin
            head = awaited_answers.pop_front();
            if (rsp_data.found_triangle !== head.found_triangle ||
                rsp_data.status !== head.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected triangle %0d status %0d, got %0d status %0d",
                           head.found_triangle, head.status,
                           rsp_data.found_triangle, rsp_data.status);
            end
         end
      end
   end

   initial begin
      int            k;
      int            n;
      stim_row_type  row;
      logic [IdxBits-1:0] settings [6];
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: coordinate extremes, deletion, vertex hits, self loops,
      // a degenerate triangle, the top indices and the unused operation.
      directed_rows.push_back(stim_row_type'{point_load(1, -8388608, -8388608), 0, '0});
      directed_rows.push_back(stim_row_type'{point_load(2, 8388607, -8388608), 0, '0});
      directed_rows.push_back(stim_row_type'{point_load(3, 0, 8388607), 0, '0});
      directed_rows.push_back(stim_row_type'{point_load(0, 0, 0), 0, '0});
      directed_rows.push_back(stim_row_type'{point_load(4095, 8388607, 8388607), 0, '0});
      directed_rows.push_back(stim_row_type'{tri_load(1, 0, 2, 3, 0, 0, 0), 0, '0});
      directed_rows.push_back(stim_row_type'{locate_req(1), 1, rsp_type'{12'd0, ST_NOT_FOUND}});
      directed_rows.push_back(stim_row_type'{tri_load(1, 1, 2, 3, 0, 0, 0), 0, '0});
      directed_rows.push_back(stim_row_type'{locate_req(1), 1, rsp_type'{12'd1, ST_VERTEX}});
      directed_rows.push_back(stim_row_type'{locate_req(3), 1, rsp_type'{12'd1, ST_VERTEX}});
      directed_rows.push_back(stim_row_type'{locate_req(0), 0, '0});
      directed_rows.push_back(stim_row_type'{locate_req(4095), 0, '0});
      directed_rows.push_back(stim_row_type'{tri_load(1, 1, 2, 3, 1, 1, 1), 0, '0});
      directed_rows.push_back(stim_row_type'{locate_req(4095), 0, '0});
      directed_rows.push_back(stim_row_type'{~locate_req(0) | {OP_UNUSED, 132'd0}, 0, '0});
      directed_rows.push_back(stim_row_type'{tri_load(4095, 4095, 4095, 4095,
                                                      4095, 4095, 4095), 0, '0});
      directed_rows.push_back(stim_row_type'{point_load(5, -1, -1), 0, '0});
      directed_rows.push_back(stim_row_type'{locate_req(5), 0, '0});
      directed_rows.push_back(stim_row_type'{tri_load(1, 2, 2, 2, 0, 0, 0), 0, '0});
      directed_rows.push_back(stim_row_type'{locate_req(0), 0, '0});
      directed_rows.push_back(stim_row_type'{locate_req(2), 1, rsp_type'{12'd1, ST_VERTEX}});
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         issue(row.req, row.typed, row.want);
      end

      // Build the working pool of points and linked triangles.
      for (k = 0; k <= PoolTop; k++)
         issue(point_load(k, $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200),
               1'b0, '0);
      for (k = 0; k <= PoolTop; k++) issue(pool_triangle(k), 1'b0, '0);

      // Random phases under several walk limits, the extremes among them.
      settings = '{12'd31, 12'd1, 12'd0, 12'd4095, 12'd2, 12'd31};
      settings[4] = IdxBits'($urandom_range(2, PoolTop - 1));
      foreach (settings[s]) begin
         set_walk_limit(settings[s]);
         for (n = 0; n < 220; n++) random_transaction();
      end

      start <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Covered %0d transactions; locates gave %0d inside, %0d on a vertex,",
               accepted, status_seen[ST_INSIDE], status_seen[ST_VERTEX]);
      $display("%0d revisits and %0d not found, over tri_count settings from 0 to 4095.",
               status_seen[ST_REVISIT], status_seen[ST_NOT_FOUND]);
      if (mismatches == 0)
         $display("mesh_point_location_walk_unit verification clean");
      else
         $display("mesh_point_location_walk_unit verification failed");
      $finish;
   end

endmodule
